[rtl/rgbpal_pkg.sv]
package rgbpal_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int INDEX_WIDTH  = 8;
  localparam int TOP_W        = 8;
  localparam int NUM_W        = SAMPLE_WIDTH + TOP_W;
  localparam int NCH          = 3;
  localparam int NB_W         = TOP_W + 1;
  localparam int NBNG_W       = 2 * TOP_W + 1;
  localparam int SUM_W        = NBNG_W + TOP_W + 1;
  localparam int PSIZE_W      = 9;
  localparam int TOPS_W       = NCH * TOP_W;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 5;
  localparam int LANE_ST      = 2 + TOP_W;
  localparam int MERGE_ST     = 2;
  localparam int NST          = LANE_ST + MERGE_ST;

  // lane order matches the channel_tops slices
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  typedef enum logic [2:0] {
    REG_RED_LOW      = 3'd0,
    REG_RED_HIGH     = 3'd1,
    REG_GREEN_LOW    = 3'd2,
    REG_GREEN_HIGH   = 3'd3,
    REG_BLUE_LOW     = 3'd4,
    REG_BLUE_HIGH    = 3'd5,
    REG_CHANNEL_TOPS = 3'd6,
    REG_PALETTE_SIZE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] lo;
    logic signed [SAMPLE_WIDTH-1:0] hi;
    logic [SAMPLE_WIDTH-1:0]        den;
    logic [TOP_W-1:0]               top;
  } lane_cfg_t;

  typedef struct packed {
    logic [NB_W-1:0]        nb;
    logic [NBNG_W-1:0]      nbng;
    logic [INDEX_WIDTH-1:0] limit;
  } merge_cfg_t;

endpackage

[rtl/rgbpal_regs.sv]
module rgbpal_regs
  import rgbpal_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  output lane_cfg_t [NCH-1:0]           lane_cfg,
  output merge_cfg_t                    merge_cfg
);

  localparam logic [PSIZE_W-1:0] IMAX = PSIZE_W'((1 << INDEX_WIDTH) - 1);

  logic [DATA_W-1:0]              lo [NCH];
  logic [DATA_W-1:0]              hi [NCH];
  logic [TOPS_W-1:0]              tops;
  logic [PSIZE_W-1:0]             psize;
  logic [SAMPLE_WIDTH-1:0]        den [NCH];
  logic [NBNG_W-1:0]              nbng;
  logic [INDEX_WIDTH-1:0]         limit;
  logic [PSIZE_W-1:0]             limit_next;
  logic                           wr;
  reg_idx_t                       idx;
  logic [NB_W-1:0]                nb;
  logic [NB_W-1:0]                ng;

  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCH; c++) begin
        lo[c] <= '0;
        hi[c] <= DATA_W'(255);
      end
      tops  <= TOPS_W'(255);
      psize <= PSIZE_W'(256);
    end else if (wr) begin
      unique case (idx)
        REG_RED_LOW:      lo[CH_RED]   <= pwdata;
        REG_RED_HIGH:     hi[CH_RED]   <= pwdata;
        REG_GREEN_LOW:    lo[CH_GREEN] <= pwdata;
        REG_GREEN_HIGH:   hi[CH_GREEN] <= pwdata;
        REG_BLUE_LOW:     lo[CH_BLUE]  <= pwdata;
        REG_BLUE_HIGH:    hi[CH_BLUE]  <= pwdata;
        REG_CHANNEL_TOPS: tops         <= pwdata[TOPS_W-1:0];
        REG_PALETTE_SIZE: psize        <= pwdata[PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RED_LOW:      prdata = lo[CH_RED];
      REG_RED_HIGH:     prdata = hi[CH_RED];
      REG_GREEN_LOW:    prdata = lo[CH_GREEN];
      REG_GREEN_HIGH:   prdata = hi[CH_GREEN];
      REG_BLUE_LOW:     prdata = lo[CH_BLUE];
      REG_BLUE_HIGH:    prdata = hi[CH_BLUE];
      REG_CHANNEL_TOPS: prdata = DATA_W'(tops);
      REG_PALETTE_SIZE: prdata = DATA_W'(psize);
      default:          prdata = '0;
    endcase
  end

  // derived values: den, nbng and limit are registered, nb and ng are combinational; only used deep in the pipe
  assign nb = NB_W'(tops[CH_BLUE*TOP_W +: TOP_W]) + NB_W'(1);
  assign ng = NB_W'(tops[CH_GREEN*TOP_W +: TOP_W]) + NB_W'(1);

  always_comb begin
    limit_next = (psize == '0) ? '0 : psize - PSIZE_W'(1);
    if (limit_next > IMAX) limit_next = IMAX;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      den[c] <= hi[c][SAMPLE_WIDTH-1:0] - lo[c][SAMPLE_WIDTH-1:0];
    end
    nbng  <= NBNG_W'(nb) * NBNG_W'(ng);
    limit <= limit_next[INDEX_WIDTH-1:0];
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      lane_cfg[c].lo  = lo[c][SAMPLE_WIDTH-1:0];
      lane_cfg[c].hi  = hi[c][SAMPLE_WIDTH-1:0];
      lane_cfg[c].den = den[c];
      lane_cfg[c].top = tops[c*TOP_W +: TOP_W];
    end
    merge_cfg.nb    = nb;
    merge_cfg.nbng  = nbng;
    merge_cfg.limit = limit;
  end

endmodule

[rtl/rgbpal_lane.sv]
module rgbpal_lane
  import rgbpal_pkg::*;
(
  input  logic                    clk,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  lane_cfg_t               cfg,
  input  logic [LANE_ST-1:0]      ld,
  output logic [TOP_W-1:0]        level
);

  logic signed [SAMPLE_WIDTH:0] s_x;
  logic signed [SAMPLE_WIDTH:0] lo_x;
  logic signed [SAMPLE_WIDTH:0] hi_x;
  logic signed [SAMPLE_WIDTH:0] d_x;
  logic                         zero_c;
  logic                         sat_c;

  logic [SAMPLE_WIDTH-1:0]      diff1;
  logic                         zero1;
  logic                         sat1;

  logic [NUM_W-1:0]             rem [TOP_W+1];
  logic [TOP_W-1:0]             q   [TOP_W+1];
  logic                         zf  [TOP_W+1];
  logic                         sf  [TOP_W+1];

  assign s_x  = {sample[SAMPLE_WIDTH-1], sample};
  assign lo_x = {cfg.lo[SAMPLE_WIDTH-1], cfg.lo};
  assign hi_x = {cfg.hi[SAMPLE_WIDTH-1], cfg.hi};
  assign d_x  = s_x - lo_x;

  assign zero_c = (cfg.top == '0) || (hi_x <= lo_x) || (s_x < lo_x);
  assign sat_c  = (s_x >= hi_x);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      diff1 <= d_x[SAMPLE_WIDTH-1:0];
      zero1 <= zero_c;
      sat1  <= sat_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      rem[0] <= {{SAMPLE_WIDTH{1'b0}}, cfg.top} * {{TOP_W{1'b0}}, diff1};
      q[0]   <= '0;
      zf[0]  <= zero1;
      sf[0]  <= sat1;
    end
  end

  // restoring divide, one quotient bit per stage, MSB first
  for (genvar k = 0; k < TOP_W; k++) begin : g_div
    logic [NUM_W-1:0] dsh;
    logic             ge;

    assign dsh = NUM_W'(cfg.den) << (TOP_W - 1 - k);
    assign ge  = rem[k] >= dsh;

    always_ff @(posedge clk) begin
      if (ld[2+k]) begin
        rem[k+1] <= ge ? rem[k] - dsh : rem[k];
        q[k+1]   <= {q[k][TOP_W-2:0], ge};
        zf[k+1]  <= zf[k];
        sf[k+1]  <= sf[k];
      end
    end
  end

  assign level = zf[TOP_W] ? '0 : (sf[TOP_W] ? cfg.top : q[TOP_W]);

endmodule

[rtl/rgbpal_merge.sv]
module rgbpal_merge
  import rgbpal_pkg::*;
(
  input  logic                         clk,
  input  logic [NCH-1:0][TOP_W-1:0]    lvl,
  input  merge_cfg_t                   cfg,
  input  logic [MERGE_ST-1:0]          ld,
  output logic [INDEX_WIDTH-1:0]       palette_index
);

  logic [TOP_W-1:0]    bl1;
  logic [NBNG_W-1:0]   tg1;
  logic [SUM_W-2:0]    tr1;
  logic [SUM_W-1:0]    sum;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      bl1 <= lvl[CH_BLUE];
      tg1 <= NBNG_W'(cfg.nb) * NBNG_W'(lvl[CH_GREEN]);
      tr1 <= (SUM_W-1)'(cfg.nbng) * (SUM_W-1)'(lvl[CH_RED]);
    end
  end

  assign sum = SUM_W'(bl1) + SUM_W'(tg1) + SUM_W'(tr1);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      palette_index <= (sum > SUM_W'(cfg.limit)) ? cfg.limit : sum[INDEX_WIDTH-1:0];
    end
  end

endmodule

[rtl/rgb_window_to_palette_index.sv]
// Maps one RGB pixel (three signed samples) to a color-cube palette index.
// Each channel goes through its own window [low, high] to a level
// floor(top*(sample-low)/(high-low)) in 0..top; the levels combine as
// b + nb*g + nb*ng*r, clamped to palette_size-1. One pixel per clock is
// accepted while the output is not stalled. The pipe is the per-channel
// 8-stage pipelined restoring divider plus input, multiply and two merge
// stages. Stalls on the output back up through the pipe, filling bubbles
// first. Register writes take effect for pixels accepted after the write
// and must only be made while no pixel is in flight.
module rgb_window_to_palette_index
  import rgbpal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] red_sample,
  input  logic [SAMPLE_WIDTH-1:0] green_sample,
  input  logic [SAMPLE_WIDTH-1:0] blue_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [INDEX_WIDTH-1:0]  palette_index
);

  lane_cfg_t [NCH-1:0]          lane_cfg;
  merge_cfg_t                   merge_cfg;
  logic [NCH-1:0][SAMPLE_WIDTH-1:0] samples;
  logic [NCH-1:0][TOP_W-1:0]    levels;
  logic [NST-1:0]               v;
  logic [NST-1:0]               ok;

  rgbpal_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .lane_cfg  (lane_cfg),
    .merge_cfg (merge_cfg)
  );

  // a stage may load when it is empty or its content moves on
  always_comb begin
    ok[NST-1] = ~v[NST-1] | out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      ok[i] = ~v[i] | ok[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~ok) | ({v[NST-2:0], in_valid} & ok);
    end
  end

  assign in_ready  = ok[0];
  assign out_valid = v[NST-1];

  assign samples[CH_RED]   = red_sample;
  assign samples[CH_GREEN] = green_sample;
  assign samples[CH_BLUE]  = blue_sample;

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    rgbpal_lane u_lane (
      .clk    (clk),
      .sample (samples[c]),
      .cfg    (lane_cfg[c]),
      .ld     (ok[LANE_ST-1:0]),
      .level  (levels[c])
    );
  end

  rgbpal_merge u_merge (
    .clk           (clk),
    .lvl           (levels),
    .cfg           (merge_cfg),
    .ld            (ok[NST-1:LANE_ST]),
    .palette_index (palette_index)
  );

endmodule
